@@ hw/rtl/pinch_gesture_detector_macros.svh @@
// Assertion macros for the pinch gesture detector.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PINCH_GESTURE_DETECTOR_MACROS_SVH
`define PINCH_GESTURE_DETECTOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PGD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pinch detector check failed (same cycle)");
// next-cycle implication
`define PGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pinch detector check failed (next cycle)");
`else
`define PGD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define PGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/pgd_pkg.sv @@
// Shared types and constants for the pinch gesture detector.
// No dependencies; imported by pgd_iter_unit and pinch_gesture_detector.
package pgd_pkg;

    localparam int          FRAC_BITS    = 8;       // Q8.8 scale fraction
    localparam int          QUO_BITS     = 16;      // scale width
    localparam logic [15:0] SCALE_ONE    = 16'd256;
    localparam logic [15:0] SCALE_MAX    = 16'hFFFF;
    localparam logic [7:0]  THRESH_RESET = 8'd25;
    localparam int          ADDR_W       = 2;
    localparam logic [1:0]  REG_THRESH   = 2'd0;    // change_threshold byte address

    // operation issued to the shared subtract/compare unit
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_SQRT_LOAD = 3'd1,
        OP_SQRT_STEP = 3'd2,
        OP_DIV_LOAD  = 3'd3,
        OP_DIV_STEP  = 3'd4
    } t_unit_op;

    typedef struct packed {
        t_unit_op op;
    } t_unit_cmd;

endpackage

@@ hw/rtl/pgd_iter_unit.sv @@
// Iterative square root / divider built around one shared subtractor.
// Depends on pgd_pkg.
module pgd_iter_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic                      i_clk,
    input  pgd_pkg::t_unit_cmd        i_cmd,
    input  logic [2*COORD_BITS+9:0]   i_radicand,
    input  logic [COORD_BITS+4:0]     i_cur,
    input  logic [COORD_BITS+4:0]     i_init,
    output logic [COORD_BITS+4:0]     o_root,
    output logic [15:0]               o_scale
);
    import pgd_pkg::*;

    localparam int R  = COORD_BITS + 5;   // root width
    localparam int W  = R + 2;            // remainder / subtractor width
    localparam int VW = 2 * R;            // radicand width

    logic [VW-1:0]       r_val;
    logic [W-1:0]        r_rem;
    logic [R-1:0]        r_root;
    logic [QUO_BITS-1:0] r_dlo;
    logic [QUO_BITS-1:0] r_quo;
    logic                r_sat;

    logic [W-1:0] w_a;
    logic [W-1:0] w_b;
    logic [W:0]   w_diff;
    logic         w_ge;

    // operand select for the shared subtractor
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_cmd.op)
            OP_SQRT_STEP: begin
                w_a = {r_rem[W-3:0], r_val[VW-1 -: 2]};
                w_b = {r_root, 2'b01};
            end
            OP_DIV_LOAD: begin
                // overflow pre-check: quotient >= 2^16 iff cur >> 8 >= init
                w_a = W'(i_cur >> FRAC_BITS);
                w_b = W'(i_init);
            end
            OP_DIV_STEP: begin
                w_a = {r_rem[W-2:0], r_dlo[QUO_BITS-1]};
                w_b = W'(i_init);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_diff = {1'b0, w_a} - {1'b0, w_b};
    assign w_ge   = ~w_diff[W];

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_SQRT_LOAD: begin
                r_val  <= VW'(i_radicand);
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQRT_STEP: begin
                r_val  <= {r_val[VW-3:0], 2'b00};
                r_rem  <= w_ge ? w_diff[W-1:0] : w_a;
                r_root <= {r_root[R-2:0], w_ge};
            end
            OP_DIV_LOAD: begin
                r_sat <= w_ge;
                r_rem <= w_a;
                r_dlo <= {i_cur[FRAC_BITS-1:0], FRAC_BITS'(0)};
                r_quo <= '0;
            end
            OP_DIV_STEP: begin
                r_dlo <= {r_dlo[QUO_BITS-2:0], 1'b0};
                r_rem <= w_ge ? w_diff[W-1:0] : w_a;
                r_quo <= {r_quo[QUO_BITS-2:0], w_ge};
            end
            default: begin
            end
        endcase
    end

    assign o_root  = r_root;
    assign o_scale = r_sat ? SCALE_MAX : r_quo;

endmodule

@@ hw/rtl/pinch_gesture_detector.sv @@
// Pinch gesture detector top level: stream ports, APB register, sequencer.
// Depends on pgd_pkg, pgd_iter_unit and pinch_gesture_detector_macros.svh.
//
//   channel   dir  beat fields (low bit first)
//   s (in)    in   tdata: touch_count, first_x, first_y, second_x, second_y
//   m (out)   out  tdata: scale_q8, focus_x, focus_y;  tuser: recognized
//   apb       in   register 0 at byte address 0: change_threshold
//
// Sequence (R = COORD_BITS + 5, 17 at the default): a frame with a count other
// than two gives its result in the cycle after acceptance; a first two-touch
// frame, or one with both distances zero, passes squares, load and root and
// skips the divide; any other two-touch frame also divides and decides. The
// root takes R passes and the divide 16 passes through the one shared subtractor.
// One frame at a time: s_tready is high only while idle, and a result beat
// holds until i_m_tready takes it. Reset (synchronous, active low) clears the
// sequencer and the pinch state and loads the threshold with 25.
`include "pinch_gesture_detector_macros.svh"
module pinch_gesture_detector #(
    parameter int COORD_BITS = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input frame stream
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // touch_count, first_x, first_y, second_x, second_y
    input  logic [((4+4*COORD_BITS+7)/8)*8-1:0]    i_s_tdata,
    // result stream
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // scale_q8, focus_x, focus_y
    output logic [((16+2*COORD_BITS+7)/8)*8-1:0]   o_m_tdata,
    // recognized
    output logic                                   o_m_tuser,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [pgd_pkg::ADDR_W-1:0]             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import pgd_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int R        = C + 5;
    localparam int VW       = 2 * R;
    localparam int SUM_W    = 2 * C + 1;
    localparam int IN_W     = ((4 + 4 * C + 7) / 8) * 8;
    localparam int OUT_W    = ((16 + 2 * C + 7) / 8) * 8;
    localparam int ITER_MAX = (R > QUO_BITS) ? R : QUO_BITS;
    localparam int CNT_W    = $clog2(ITER_MAX);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b0_0000_0001,
        ST_SQ_X   = 9'b0_0000_0010,
        ST_SQ_Y   = 9'b0_0000_0100,
        ST_LOAD   = 9'b0_0000_1000,
        ST_ROOT   = 9'b0_0001_0000,
        ST_START  = 9'b0_0010_0000,
        ST_DIV    = 9'b0_0100_0000,
        ST_DECIDE = 9'b0_1000_0000,
        ST_OUT    = 9'b1_0000_0000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [3:0]       r_count;
    logic [C-1:0]     r_x1, r_y1, r_x2, r_y2;
    logic [2*C-1:0]   r_prod;
    logic [2*C-1:0]   r_sum;
    logic             r_started;
    logic [R-1:0]     r_init;
    logic [15:0]      r_held_scale;
    logic [C-1:0]     r_focus_x;
    logic [C-1:0]     r_focus_y;
    logic             r_recog;
    logic [7:0]       r_thr;

    logic             w_s_acc;
    logic             w_m_acc;
    logic             w_cfg_wr;
    logic [3:0]       w_count;
    logic [C-1:0]     w_dx, w_dy;
    logic [C-1:0]     w_sq_in;
    logic [VW-1:0]    w_rad;
    logic [R-1:0]     w_root;
    logic [15:0]      w_scale;
    logic [15:0]      w_dev;
    logic [15:0]      w_held_dev;
    logic [C-1:0]     w_mid_x, w_mid_y;
    logic             w_iter_last;
    t_unit_cmd        w_cmd;

    // handshakes
    assign w_s_acc    = i_s_tvalid & o_s_tready;
    assign w_m_acc    = o_m_tvalid & i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_OUT);
    assign w_count    = i_s_tdata[3:0];

    // APB: single register, always ready
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign prdata   = (paddr == REG_THRESH) ? {24'd0, r_thr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESH_RESET;
        end else if (w_cfg_wr && paddr == REG_THRESH) begin
            r_thr <= pwdata[7:0];
        end
    end

    // geometry of the latched frame
    assign w_dx    = (r_x1 > r_x2) ? (r_x1 - r_x2) : (r_x2 - r_x1);
    assign w_dy    = (r_y1 > r_y2) ? (r_y1 - r_y2) : (r_y2 - r_y1);
    // one squarer, fed dx then dy
    assign w_sq_in = (r_state == ST_SQ_X) ? w_dx : w_dy;
    // (dx^2 + dy^2) * 256 for a Q.4 root
    assign w_rad   = VW'({SUM_W'(r_sum) + SUM_W'(r_prod), FRAC_BITS'(0)});
    assign w_mid_x = C'(({1'b0, r_x1} + {1'b0, r_x2}) >> 1);
    assign w_mid_y = C'(({1'b0, r_y1} + {1'b0, r_y2}) >> 1);

    // |scale - 1.0|
    assign w_dev      = (w_scale >= SCALE_ONE) ? (w_scale - SCALE_ONE)
                                               : (SCALE_ONE - w_scale);
    assign w_held_dev = (r_held_scale >= SCALE_ONE) ? (r_held_scale - SCALE_ONE)
                                                    : (SCALE_ONE - r_held_scale);

    assign w_iter_last = (r_state == ST_ROOT) ? (r_cnt == CNT_W'(R - 1))
                                              : (r_cnt == CNT_W'(QUO_BITS - 1));

    // shared unit command
    always_comb begin
        w_cmd.op = OP_NONE;
        case (r_state)
            ST_LOAD:  w_cmd.op = OP_SQRT_LOAD;
            ST_ROOT:  w_cmd.op = OP_SQRT_STEP;
            ST_START: w_cmd.op = OP_DIV_LOAD;
            ST_DIV:   w_cmd.op = OP_DIV_STEP;
            default:  w_cmd.op = OP_NONE;
        endcase
    end

    pgd_iter_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_iter (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_radicand (w_rad),
        .i_cur      (w_root),
        .i_init     (r_init),
        .o_root     (w_root),
        .o_scale    (w_scale)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    n_state = (w_count == 4'd2) ? ST_SQ_X : ST_OUT;
                end
            end
            ST_SQ_X: n_state = ST_SQ_Y;
            ST_SQ_Y: n_state = ST_LOAD;
            ST_LOAD: n_state = ST_ROOT;
            ST_ROOT: begin
                if (w_iter_last) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                // first frame or both distances zero: no divide
                if (!r_started || (r_init == '0 && w_root == '0)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_iter_last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: n_state = ST_OUT;
            ST_OUT: begin
                if (w_m_acc) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_started    <= 1'b0;
            r_init       <= '0;
            r_held_scale <= SCALE_ONE;
            r_focus_x    <= '0;
            r_focus_y    <= '0;
            r_recog      <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (w_s_acc) begin
                        r_recog <= 1'b0;
                        if (w_count != 4'd2) begin
                            // pinch ends: back to reset values
                            r_started    <= 1'b0;
                            r_init       <= '0;
                            r_held_scale <= SCALE_ONE;
                            r_focus_x    <= '0;
                            r_focus_y    <= '0;
                        end
                    end
                end
                ST_ROOT: begin
                    r_cnt <= w_iter_last ? '0 : r_cnt + 1'b1;
                end
                ST_START: begin
                    r_cnt <= '0;
                    if (!r_started) begin
                        r_init       <= w_root;
                        r_started    <= 1'b1;
                        r_held_scale <= SCALE_ONE;
                    end
                end
                ST_DIV: begin
                    r_cnt <= w_iter_last ? '0 : r_cnt + 1'b1;
                end
                ST_DECIDE: begin
                    if (w_dev > {8'd0, r_thr}) begin
                        r_held_scale <= w_scale;
                        r_focus_x    <= w_mid_x;
                        r_focus_y    <= w_mid_y;
                        r_recog      <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // frame payload and squares
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_count <= w_count;
            r_x1    <= i_s_tdata[4 +: C];
            r_y1    <= i_s_tdata[4 + C +: C];
            r_x2    <= i_s_tdata[4 + 2*C +: C];
            r_y2    <= i_s_tdata[4 + 3*C +: C];
        end
        case (r_state)
            ST_SQ_X: r_prod <= w_sq_in * w_sq_in;
            ST_SQ_Y: begin
                r_sum  <= r_prod;
                r_prod <= w_sq_in * w_sq_in;
            end
            default: begin
            end
        endcase
    end

    assign o_m_tdata = OUT_W'({r_focus_y, r_focus_x, r_held_scale});
    assign o_m_tuser = r_recog;

    // checks
    `PGD_ASSERT_IMPLIES(a_no_accept_while_holding, i_clk, i_rst_n,
        o_m_tvalid, !o_s_tready)
    `PGD_ASSERT_NEXT(a_clear_on_release, i_clk, i_rst_n,
        w_s_acc && (w_count != 4'd2), (!r_started && r_held_scale == SCALE_ONE))
    `PGD_ASSERT_IMPLIES(a_recog_exceeds_thr, i_clk, i_rst_n,
        o_m_tvalid && o_m_tuser, (w_held_dev > {8'd0, r_thr}))
    `PGD_ASSERT_IMPLIES(a_started_two_touch, i_clk, i_rst_n,
        r_started && (r_state != ST_IDLE) && (r_state != ST_OUT), (r_count == 4'd2))

endmodule
